@@ hw/rtl/program_stream_pes_parser_macros.svh @@
// assertion macros for the program stream pes parser
// used by the top level only
`ifndef PROGRAM_STREAM_PES_PARSER_MACROS_SVH
`define PROGRAM_STREAM_PES_PARSER_MACROS_SVH
// implication checked on every edge outside reset
`define PSP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("psp check failed");
// implication whose consequent is checked in the next cycle
`define PSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psp check failed");
`endif

@@ hw/rtl/psp_pkg.sv @@
// shared types and constants for the program stream pes parser
// no dependencies
package psp_pkg;

    localparam int POSITION_BITS = 48;

    typedef enum logic [4:0] {
        PH_HUNT, PH_SKLEN_HI, PH_SKLEN_LO, PH_SKIP, PH_LEN_HI, PH_LEN_LO,
        PH_FIRST, PH_M2_FLAGS, PH_M2_HLEN, PH_M2_STAMP, PH_M2_REST,
        PH_PRIV_ID, PH_PRIV_SKIP, PH_M1_STD, PH_M1_C, PH_M1_STAMP,
        PH_M1_DTS, PH_EMIT, PH_DROP
    } phase_t;

    localparam logic [7:0] SID_PACK    = 8'hBA;
    localparam logic [7:0] SID_SYSTEM  = 8'hBB;
    localparam logic [7:0] SID_PRIV1   = 8'hBD;
    localparam logic [7:0] SID_PADDING = 8'hBE;
    localparam logic [7:0] SID_PRIV2   = 8'hBF;
    localparam logic [7:0] SUB_NONE    = 8'hFF;

    localparam logic [0:0] CFG_SELECTED = 1'b0;
    localparam logic [0:0] CFG_PASS_ALL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  stream_id;
        logic [15:0] payload_length;
        logic [32:0] pts;
        logic        pts_valid;
        logic [32:0] dts;
        logic        dts_valid;
        logic [POSITION_BITS-1:0] start_offset;
        logic [7:0]  data_byte;
        logic        last;
    } result_t;

    function automatic logic [32:0] stamp_shift(input logic [32:0] acc,
                                                input logic [3:0] idx,
                                                input logic [7:0] b);
        logic [3:0] r;
        begin
            r = (idx >= 4'd5) ? idx - 4'd5 : idx;
            case (r)
                4'd0: stamp_shift = {30'd0, b[3:1]};
                4'd1, 4'd3: stamp_shift = {acc[24:0], b};
                default: stamp_shift = {acc[25:0], b[7:1]};
            endcase
        end
    endfunction

    function automatic logic stream_accepted(input logic [7:0] s);
        begin
            stream_accepted = (s >= 8'hC0 && s < 8'hC9) || (s >= 8'hE0 && s < 8'hE9) ||
                              (s >= 8'h20 && s < 8'h29) || s == SID_PRIV1 ||
                              s == SID_PRIV2;
        end
    endfunction

endpackage

@@ hw/rtl/psp_out_reg.sv @@
// output register stage holding one result beat
// depends on psp_pkg
module psp_out_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  psp_pkg::result_t   din,
    input  logic               take,
    output logic               full,
    output psp_pkg::result_t   dout
);
    logic full_reg;
    psp_pkg::result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (load) begin
            full_reg <= 1'b1;
        end else if (take) begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= din;
        end
    end

    assign full = full_reg;
    assign dout = data_reg;
endmodule

@@ hw/rtl/program_stream_pes_parser.sv @@
// program stream pes parser: byte parser state machine plus result register
// depends on psp_pkg, psp_out_reg and program_stream_pes_parser_macros.svh
//
// usage: bytes of a program stream enter on s_valid/s_ready, one per beat.
// packets of the selected stream (or every stream when pass_all_streams is
// set) leave on m_valid/m_ready: one header beat (item_kind 0) with id,
// length, time stamps and start offset, then one beat per payload byte
// (item_kind 1), with last on the final beat of the packet.
// each byte is parsed in the cycle it is accepted; a result it causes is
// valid on the next cycle, and throughput is one byte per cycle while
// s_ready is high. the state update and time stamp shift sit between the
// accepted byte and the result register.
// when the receiver stalls, the result register holds its beat and s_ready
// stays high only while that register is empty or being drained this cycle.
// reset (aresetn low, synchronous) returns to start code hunting with an
// empty window, selected_stream E0 and pass_all_streams 0.
// configuration writes are taken on cfg_we with cfg_index 0 or 1.
`include "program_stream_pes_parser_macros.svh"
module program_stream_pes_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_item_kind,
    output logic [7:0]  m_stream_id,
    output logic [15:0] m_payload_length,
    output logic [32:0] m_pts,
    output logic        m_pts_valid,
    output logic [32:0] m_dts,
    output logic        m_dts_valid,
    output logic [psp_pkg::POSITION_BITS-1:0] m_start_offset,
    output logic [7:0]  m_data_byte,
    output logic        m_last
);
    localparam int PB = psp_pkg::POSITION_BITS;

    logic [7:0] sel_reg;
    logic pass_reg;
    logic [23:0] win_reg, win_next;
    psp_pkg::phase_t ph_reg, ph_next;
    logic [7:0] cur_reg, cur_next, sub_reg, sub_next;
    logic [15:0] size_reg, size_next, skip_reg, skip_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [32:0] pts_reg, pts_next, dts_reg, dts_next;
    logic [2:0] flags_reg, flags_next;
    logic [PB-1:0] pos_reg, start_reg, start_next;

    logic fire, emit, full;
    psp_pkg::result_t res, dout;

    assign s_ready = !full || m_ready;
    assign fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 8'hE0;
            pass_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                psp_pkg::CFG_SELECTED: sel_reg <= cfg_data;
                psp_pkg::CFG_PASS_ALL: pass_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '1; ph_reg <= psp_pkg::PH_HUNT; cur_reg <= '0;
            sub_reg <= psp_pkg::SUB_NONE; size_reg <= '0; hdr_reg <= '0;
            skip_reg <= '0; pts_reg <= '0; dts_reg <= '0; flags_reg <= '0;
            pos_reg <= '0; start_reg <= '0;
        end else if (fire) begin
            win_reg <= win_next; ph_reg <= ph_next; cur_reg <= cur_next;
            sub_reg <= sub_next; size_reg <= size_next; hdr_reg <= hdr_next;
            skip_reg <= skip_next; pts_reg <= pts_next; dts_reg <= dts_next;
            flags_reg <= flags_next; pos_reg <= pos_reg + 1'b1;
            start_reg <= start_next;
        end
    end

    always_comb begin
        logic [7:0] b, id, s;
        logic [15:0] sz;
        logic [1:0] code;
        logic [3:0] endc;
        logic [15:0] extra;
        logic ok, fin;
        b = s_in_byte;
        win_next = win_reg; ph_next = ph_reg; cur_next = cur_reg; sub_next = sub_reg;
        size_next = size_reg; hdr_next = hdr_reg; skip_next = skip_reg;
        pts_next = pts_reg; dts_next = dts_reg; flags_next = flags_reg;
        start_next = start_reg;
        emit = 1'b0; fin = 1'b0;
        res = '0;
        ok = size_reg != 16'd0;
        sz = ok ? size_reg - 16'd1 : 16'd0;
        code = 2'd0; endc = 4'd0; s = b; extra = 16'd0; id = 8'd0;
        unique case (ph_reg)
            psp_pkg::PH_HUNT: begin
                if (win_reg == 24'h000001) begin
                    cur_next = b; start_next = pos_reg - PB'(3);
                    win_next = '1; sub_next = psp_pkg::SUB_NONE;
                    pts_next = '0; dts_next = '0; flags_next = '0;
                    size_next = '0; hdr_next = '0;
                    if (b == psp_pkg::SID_PACK) begin
                        skip_next = 16'd8; ph_next = psp_pkg::PH_SKIP;
                    end else if (b == psp_pkg::SID_PADDING || b == psp_pkg::SID_SYSTEM) begin
                        ph_next = psp_pkg::PH_SKLEN_HI;
                    end else if (psp_pkg::stream_accepted(b)) begin
                        ph_next = psp_pkg::PH_LEN_HI;
                    end
                end else begin
                    win_next = {win_reg[15:0], b};
                end
            end
            psp_pkg::PH_SKLEN_HI: begin
                skip_next = {b, 8'd0}; ph_next = psp_pkg::PH_SKLEN_LO;
            end
            psp_pkg::PH_SKLEN_LO: begin
                skip_next = {skip_reg[15:8], b};
                if (skip_next != 16'd0) ph_next = psp_pkg::PH_SKIP;
                else begin ph_next = psp_pkg::PH_HUNT; win_next = '1; end
            end
            psp_pkg::PH_SKIP, psp_pkg::PH_DROP: begin
                if (ph_reg == psp_pkg::PH_SKIP) begin
                    skip_next = (skip_reg != 0) ? skip_reg - 16'd1 : 16'd0;
                    if (skip_next == 0) begin ph_next = psp_pkg::PH_HUNT; win_next = '1; end
                end else begin
                    size_next = sz;
                    if (sz == 0) begin ph_next = psp_pkg::PH_HUNT; win_next = '1; end
                end
            end
            psp_pkg::PH_LEN_HI: begin
                size_next = {b, 8'd0}; ph_next = psp_pkg::PH_LEN_LO;
            end
            psp_pkg::PH_LEN_LO: begin
                size_next = {size_reg[15:8], b};
                if (cur_reg == psp_pkg::SID_PRIV2) fin = 1'b1;
                else ph_next = psp_pkg::PH_FIRST;
            end
            psp_pkg::PH_EMIT: begin
                size_next = sz; emit = 1'b1;
                res.kind = 1'b1; res.data_byte = b; res.last = sz == 0;
                if (sz == 0) begin ph_next = psp_pkg::PH_HUNT; win_next = '1; end
            end
            default: begin
                // every header phase counts the byte against the packet length
                if (!ok) begin
                    ph_next = psp_pkg::PH_HUNT; win_next = '1;
                end else begin
                    size_next = sz;
                    unique case (ph_reg)
                        psp_pkg::PH_FIRST, psp_pkg::PH_M1_C: begin
                            if (ph_reg == psp_pkg::PH_FIRST && b == 8'hFF) begin
                            end else if (ph_reg == psp_pkg::PH_FIRST && b[7:6] == 2'b10) begin
                                ph_next = psp_pkg::PH_M2_FLAGS;
                            end else if (ph_reg == psp_pkg::PH_FIRST && b[7:6] == 2'b01) begin
                                ph_next = psp_pkg::PH_M1_STD;
                            end else if (b[7:4] == 4'd1) begin
                                ph_next = psp_pkg::PH_HUNT; win_next = '1;
                            end else if (b[7:4] == 4'd2 || b[7:4] == 4'd3) begin
                                pts_next = {30'd0, b[3:1]}; skip_next = 16'd1;
                                flags_next = {b[4], 2'b01};
                                ph_next = psp_pkg::PH_M1_STAMP;
                            end else fin = 1'b1;
                        end
                        psp_pkg::PH_M1_STD: ph_next = psp_pkg::PH_M1_C;
                        psp_pkg::PH_M1_STAMP: begin
                            pts_next = psp_pkg::stamp_shift(pts_reg, skip_reg[3:0], b);
                            skip_next = skip_reg + 16'd1;
                            if (skip_next >= 16'd5) begin
                                if (flags_reg[2]) begin
                                    skip_next = 16'd5; ph_next = psp_pkg::PH_M1_DTS;
                                end else fin = 1'b1;
                            end
                        end
                        psp_pkg::PH_M1_DTS, psp_pkg::PH_PRIV_SKIP: begin
                            skip_next = (skip_reg != 0) ? skip_reg - 16'd1 : 16'd0;
                            if (skip_next == 0) fin = 1'b1;
                        end
                        psp_pkg::PH_M2_FLAGS: begin
                            flags_next = {1'b0, b[7:6]}; ph_next = psp_pkg::PH_M2_HLEN;
                        end
                        psp_pkg::PH_M2_HLEN: begin
                            hdr_next = b; code = flags_reg[1:0]; flags_next = '0;
                            if (code == 2'd1) begin
                                ph_next = psp_pkg::PH_HUNT; win_next = '1;
                            end else if ((code == 2'd2 && b >= 8'd5) ||
                                         (code == 2'd3 && b >= 8'd10)) begin
                                flags_next = (code == 2'd3) ? 3'd3 : 3'd1;
                                skip_next = '0; ph_next = psp_pkg::PH_M2_STAMP;
                            end else if (b != 0) ph_next = psp_pkg::PH_M2_REST;
                            else if (cur_reg == psp_pkg::SID_PRIV1 && sz > 16'd5)
                                ph_next = psp_pkg::PH_PRIV_ID;
                            else fin = 1'b1;
                        end
                        psp_pkg::PH_M2_STAMP: begin
                            endc = (flags_reg == 3'd3) ? 4'd10 : 4'd5;
                            if (skip_reg < 16'd5)
                                pts_next = psp_pkg::stamp_shift(pts_reg, skip_reg[3:0], b);
                            else
                                dts_next = psp_pkg::stamp_shift(dts_reg, skip_reg[3:0], b);
                            skip_next = skip_reg + 16'd1;
                            if (skip_next >= {12'd0, endc}) begin
                                hdr_next = (hdr_reg >= {4'd0, endc}) ?
                                           hdr_reg - {4'd0, endc} : 8'd0;
                                if (hdr_next != 0) ph_next = psp_pkg::PH_M2_REST;
                                else if (cur_reg == psp_pkg::SID_PRIV1 && sz > 16'd5)
                                    ph_next = psp_pkg::PH_PRIV_ID;
                                else fin = 1'b1;
                            end
                        end
                        psp_pkg::PH_M2_REST: begin
                            hdr_next = (hdr_reg != 0) ? hdr_reg - 8'd1 : 8'd0;
                            if (hdr_next == 0) begin
                                if (cur_reg == psp_pkg::SID_PRIV1 && sz > 16'd5)
                                    ph_next = psp_pkg::PH_PRIV_ID;
                                else fin = 1'b1;
                            end
                        end
                        psp_pkg::PH_PRIV_ID: begin
                            if (b >= 8'h88 && b <= 8'h8B) s = b - 8'h48;
                            else if (b >= 8'h80 && b <= 8'h87) s = b - 8'h80;
                            else if (b >= 8'hA0 && b <= 8'hA7) extra = 16'd3;
                            else if (b >= 8'h20 && b <= 8'h27) s = b;
                            else s = psp_pkg::SUB_NONE;
                            sub_next = s;
                            if (s > 8'h26 || s < 8'h20) extra = extra + 16'd3;
                            if (extra != 0) begin
                                skip_next = extra; ph_next = psp_pkg::PH_PRIV_SKIP;
                            end else fin = 1'b1;
                        end
                        default: begin ph_next = psp_pkg::PH_HUNT; win_next = '1; end
                    endcase
                end
            end
        endcase
        if (fin) begin
            id = (cur_reg == psp_pkg::SID_PRIV1) ? sub_next : cur_reg;
            if (pass_reg || id == sel_reg) begin
                emit = 1'b1;
                res.stream_id = id;
                res.payload_length = size_next;
                res.pts_valid = flags_next[0];
                res.dts_valid = flags_next[1];
                res.pts = flags_next[0] ? pts_next : 33'd0;
                res.dts = flags_next[1] ? dts_next : 33'd0;
                res.last = size_next == 0;
                ph_next = (size_next != 0) ? psp_pkg::PH_EMIT : psp_pkg::PH_HUNT;
            end else begin
                ph_next = (size_next != 0) ? psp_pkg::PH_DROP : psp_pkg::PH_HUNT;
            end
            if (size_next == 0) win_next = '1;
        end
        if (ph_reg == psp_pkg::PH_EMIT) res.stream_id =
            (cur_reg == psp_pkg::SID_PRIV1) ? sub_reg : cur_reg;
        res.start_offset = start_next;
    end

    psp_out_reg u_out (
        .aclk(aclk), .aresetn(aresetn), .load(fire && emit), .din(res),
        .take(m_ready), .full(full), .dout(dout)
    );

    assign m_valid = full;
    assign m_item_kind = dout.kind;
    assign m_stream_id = dout.stream_id;
    assign m_payload_length = dout.payload_length;
    assign m_pts = dout.pts;
    assign m_pts_valid = dout.pts_valid;
    assign m_dts = dout.dts;
    assign m_dts_valid = dout.dts_valid;
    assign m_start_offset = dout.start_offset;
    assign m_data_byte = dout.data_byte;
    assign m_last = dout.last;

    `PSP_ASSERT_IMP(a_no_overwrite, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `PSP_ASSERT_NEXT(a_emit_shows, aclk, aresetn, fire && emit, m_valid)
    `PSP_ASSERT_IMP(a_payload_clean, aclk, aresetn, m_valid && m_item_kind,
                    m_payload_length == 16'd0 && !m_pts_valid && !m_dts_valid)
    `PSP_ASSERT_IMP(a_hunt_no_emit, aclk, aresetn,
                    fire && ph_reg == psp_pkg::PH_HUNT, !emit)
endmodule

@@ test/tb_top.sv @@
// testbench for program_stream_pes_parser: random program streams with checked results
// depends on psp_pkg and the parser rtl; holds its own byte-level parser model
`timescale 1ns / 100ps

module tb_top;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = psp_pkg::CFG_SELECTED;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_item_kind;
    logic [7:0]  m_stream_id;
    logic [15:0] m_payload_length;
    logic [32:0] m_pts;
    logic        m_pts_valid;
    logic [32:0] m_dts;
    logic        m_dts_valid;
    logic [psp_pkg::POSITION_BITS-1:0] m_start_offset;
    logic [7:0]  m_data_byte;
    logic        m_last;

    program_stream_pes_parser i_dut (.*);

    always #4 aclk = ~aclk;

    logic [7:0] stream_bytes[$];
    psp_pkg::result_t expected_beats[$];
    int         bytes_in_flight = 0;
    int         errors = 0;
    int         hold_cycles = 0;
    bit         gaps_off = 1'b0;

    // parser model state
    logic [7:0]  sel_sid = 8'hE0;
    logic        pass_all = 1'b0;
    logic [23:0] win = 24'hFFFFFF;
    psp_pkg::phase_t ph = psp_pkg::PH_HUNT;
    logic [7:0]  cur_sid = 8'h00;
    logic [7:0]  sub_sid = psp_pkg::SUB_NONE;
    logic [15:0] remaining = 16'd0;
    logic [7:0]  hdr_left = 8'd0;
    logic [15:0] skip_cnt = 16'd0;
    logic [32:0] pts_acc = 33'd0;
    logic [32:0] dts_acc = 33'd0;
    logic [2:0]  flags = 3'd0;
    logic [psp_pkg::POSITION_BITS-1:0] pos = '0;
    logic [psp_pkg::POSITION_BITS-1:0] pkt_start = '0;

    function automatic logic [32:0] ts_shift(logic [32:0] acc, int idx, logic [7:0] b);
        case (idx % 5)
            0: return {30'd0, b[3:1]};
            1, 3: return {acc[24:0], b};
            default: return {acc[25:0], b[7:1]};
        endcase
    endfunction

    function automatic logic [7:0] beat_sid();
        return cur_sid == psp_pkg::SID_PRIV1 ? sub_sid : cur_sid;
    endfunction

    task automatic hunt();
        ph = psp_pkg::PH_HUNT;
        win = 24'hFFFFFF;
    endtask

    task automatic push_beat(logic kind, logic [15:0] len, logic [32:0] pts, logic pv,
                             logic [32:0] dts, logic dv, logic [7:0] data, logic lst);
        psp_pkg::result_t r;
        r.kind = kind;
        r.stream_id = beat_sid();
        r.payload_length = len;
        r.pts = pts;
        r.pts_valid = pv;
        r.dts = dts;
        r.dts_valid = dv;
        r.start_offset = pkt_start;
        r.data_byte = data;
        r.last = lst;
        expected_beats.push_back(r);
    endtask

    task automatic close_header();
        if (pass_all || beat_sid() == sel_sid) begin
            push_beat(1'b0, remaining, flags[0] ? pts_acc : 33'd0, flags[0],
                      flags[1] ? dts_acc : 33'd0, flags[1], 8'h00, remaining == 0);
            if (remaining != 0) ph = psp_pkg::PH_EMIT; else hunt();
        end else begin
            if (remaining != 0) ph = psp_pkg::PH_DROP; else hunt();
        end
    endtask

    // header byte against packet length; underflow drops the packet
    function automatic bit take();
        if (remaining == 0) begin
            ph = psp_pkg::PH_HUNT;
            win = 24'hFFFFFF;
            return 1'b0;
        end
        remaining--;
        return 1'b1;
    endfunction

    task automatic mpeg1_code(logic [7:0] c);
        if (c[7:4] == 4'd1) begin
            hunt();
        end else if (c[7:4] == 4'd2 || c[7:4] == 4'd3) begin
            pts_acc = ts_shift(33'd0, 0, c);
            skip_cnt = 16'd1;
            flags = (c[7:4] == 4'd3) ? 3'd5 : 3'd1;
            ph = psp_pkg::PH_M1_STAMP;
        end else begin
            close_header();
        end
    endtask

    task automatic after_mpeg2();
        if (cur_sid == psp_pkg::SID_PRIV1 && remaining > 5) ph = psp_pkg::PH_PRIV_ID;
        else close_header();
    endtask

    function automatic bit sid_ok(logic [7:0] s);
        return (s >= 8'hC0 && s < 8'hC9) || (s >= 8'hE0 && s < 8'hE9) ||
               (s >= 8'h20 && s < 8'h29) || s == psp_pkg::SID_PRIV1 ||
               s == psp_pkg::SID_PRIV2;
    endfunction

    task automatic parse_byte(logic [7:0] b);
        logic [1:0] code;
        int stamp_end;
        logic [7:0] s;
        int extra;
        logic [psp_pkg::POSITION_BITS-1:0] here;
        here = pos;
        pos = pos + 1'b1;
        case (ph)
            psp_pkg::PH_HUNT: begin
                if (win == 24'h000001) begin
                    cur_sid = b;
                    pkt_start = here - 3;
                    win = 24'hFFFFFF;
                    sub_sid = psp_pkg::SUB_NONE;
                    pts_acc = '0;
                    dts_acc = '0;
                    flags = '0;
                    remaining = '0;
                    hdr_left = '0;
                    if (b == psp_pkg::SID_PACK) begin
                        skip_cnt = 16'd8;
                        ph = psp_pkg::PH_SKIP;
                    end else if (b == psp_pkg::SID_PADDING || b == psp_pkg::SID_SYSTEM) begin
                        ph = psp_pkg::PH_SKLEN_HI;
                    end else if (sid_ok(b)) begin
                        ph = psp_pkg::PH_LEN_HI;
                    end
                end else begin
                    win = {win[15:0], b};
                end
            end
            psp_pkg::PH_SKLEN_HI: begin
                skip_cnt = {b, 8'h00};
                ph = psp_pkg::PH_SKLEN_LO;
            end
            psp_pkg::PH_SKLEN_LO: begin
                skip_cnt[7:0] = b;
                if (skip_cnt != 0) ph = psp_pkg::PH_SKIP; else hunt();
            end
            psp_pkg::PH_SKIP: begin
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) hunt();
            end
            psp_pkg::PH_LEN_HI: begin
                remaining = {b, 8'h00};
                ph = psp_pkg::PH_LEN_LO;
            end
            psp_pkg::PH_LEN_LO: begin
                remaining[7:0] = b;
                if (cur_sid == psp_pkg::SID_PRIV2) close_header();
                else ph = psp_pkg::PH_FIRST;
            end
            psp_pkg::PH_FIRST: begin
                if (take() && b != 8'hFF) begin
                    if (b[7:6] == 2'b10) ph = psp_pkg::PH_M2_FLAGS;
                    else if (b[7:6] == 2'b01) ph = psp_pkg::PH_M1_STD;
                    else mpeg1_code(b);
                end
            end
            psp_pkg::PH_M1_STD: if (take()) ph = psp_pkg::PH_M1_C;
            psp_pkg::PH_M1_C: if (take()) mpeg1_code(b);
            psp_pkg::PH_M1_STAMP: begin
                if (take()) begin
                    pts_acc = ts_shift(pts_acc, skip_cnt, b);
                    skip_cnt++;
                    if (skip_cnt >= 5) begin
                        if (flags[2]) begin
                            skip_cnt = 16'd5;
                            ph = psp_pkg::PH_M1_DTS;
                        end else begin
                            close_header();
                        end
                    end
                end
            end
            psp_pkg::PH_M1_DTS: begin
                if (take()) begin
                    if (skip_cnt != 0) skip_cnt--;
                    if (skip_cnt == 0) close_header();
                end
            end
            psp_pkg::PH_M2_FLAGS: begin
                if (take()) begin
                    flags = {1'b0, b[7:6]};
                    ph = psp_pkg::PH_M2_HLEN;
                end
            end
            psp_pkg::PH_M2_HLEN: begin
                if (take()) begin
                    hdr_left = b;
                    code = flags[1:0];
                    flags = '0;
                    if (code == 2'd1) begin
                        hunt();
                    end else if ((code == 2'd2 && b >= 5) || (code == 2'd3 && b >= 10)) begin
                        flags = (code == 2'd3) ? 3'd3 : 3'd1;
                        skip_cnt = '0;
                        ph = psp_pkg::PH_M2_STAMP;
                    end else if (hdr_left != 0) begin
                        ph = psp_pkg::PH_M2_REST;
                    end else begin
                        after_mpeg2();
                    end
                end
            end
            psp_pkg::PH_M2_STAMP: begin
                stamp_end = (flags == 3'd3) ? 10 : 5;
                if (take()) begin
                    if (skip_cnt < 5) pts_acc = ts_shift(pts_acc, skip_cnt, b);
                    else dts_acc = ts_shift(dts_acc, skip_cnt - 5, b);
                    skip_cnt++;
                    if (skip_cnt >= stamp_end) begin
                        hdr_left = (hdr_left >= stamp_end) ? 8'(hdr_left - stamp_end) : 8'd0;
                        if (hdr_left != 0) ph = psp_pkg::PH_M2_REST; else after_mpeg2();
                    end
                end
            end
            psp_pkg::PH_M2_REST: begin
                if (take()) begin
                    if (hdr_left != 0) hdr_left--;
                    if (hdr_left == 0) after_mpeg2();
                end
            end
            psp_pkg::PH_PRIV_ID: begin
                if (take()) begin
                    extra = 0;
                    if (b >= 8'h88 && b <= 8'h8B) s = b - 8'h48;
                    else if (b >= 8'h80 && b <= 8'h87) s = b - 8'h80;
                    else if (b >= 8'hA0 && b <= 8'hA7) begin
                        s = b;
                        extra = 3;
                    end else if (b >= 8'h20 && b <= 8'h27) s = b;
                    else s = psp_pkg::SUB_NONE;
                    sub_sid = s;
                    // only subtitle ids 20-26 carry no audio header
                    if (s > 8'h26 || s < 8'h20) extra += 3;
                    if (extra != 0) begin
                        skip_cnt = 16'(extra);
                        ph = psp_pkg::PH_PRIV_SKIP;
                    end else begin
                        close_header();
                    end
                end
            end
            psp_pkg::PH_PRIV_SKIP: begin
                if (take()) begin
                    if (skip_cnt != 0) skip_cnt--;
                    if (skip_cnt == 0) close_header();
                end
            end
            psp_pkg::PH_EMIT: begin
                if (remaining != 0) remaining--;
                push_beat(1'b1, 16'd0, 33'd0, 1'b0, 33'd0, 1'b0, b, remaining == 0);
                if (remaining == 0) hunt();
            end
            psp_pkg::PH_DROP: begin
                if (remaining != 0) remaining--;
                if (remaining == 0) hunt();
            end
            default: hunt();
        endcase
    endtask

    // sender: one byte per beat, valid held until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_in_byte);
                bytes_in_flight--;
            end
            if (!s_valid || s_ready) begin
                if (stream_bytes.size() != 0 && (gaps_off || $urandom_range(99) >= 38)) begin
                    s_valid <= 1'b1;
                    s_in_byte <= stream_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // receiver: checks every result beat against the oldest expectation
    always @(posedge aclk) begin
        psp_pkg::result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat, actual kind %0d id %0h",
                         $time, m_item_kind, m_stream_id);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                check_field("item_kind", e.kind, m_item_kind);
                check_field("stream_id", e.stream_id, m_stream_id);
                check_field("payload_length", e.payload_length, m_payload_length);
                check_field("pts", e.pts, m_pts);
                check_field("pts_valid", e.pts_valid, m_pts_valid);
                check_field("dts", e.dts, m_dts);
                check_field("dts_valid", e.dts_valid, m_dts_valid);
                check_field("start_offset", e.start_offset, m_start_offset);
                check_field("data_byte", e.data_byte, m_data_byte);
                check_field("last", e.last, m_last);
            end
        end
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (gaps_off || $urandom_range(99) >= 38);
        end
    end

    task automatic put_byte(logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_in_flight++;
    endtask

    task automatic put_start(logic [7:0] sid);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(sid);
    endtask

    task automatic put_pes();
        logic [7:0] sid;
        logic [7:0] hdr[$];
        logic [1:0] code;
        int hl, plen, len, k;
        case ($urandom_range(5))
            0: sid = 8'hC0 + 8'($urandom_range(8));
            1: sid = 8'hE0 + 8'($urandom_range(8));
            2: sid = 8'h20 + 8'($urandom_range(8));
            3, 4: sid = psp_pkg::SID_PRIV1;
            default: sid = psp_pkg::SID_PRIV2;
        endcase
        if (sid != psp_pkg::SID_PRIV2) begin
            if ($urandom_range(3) != 0) begin
                hdr.push_back(8'h80 | 8'($urandom_range(63)));
                code = 2'($urandom_range(3));
                if (code == 2'd1 && $urandom_range(3) != 0) code = 2'd2;
                hdr.push_back({code, 6'($urandom_range(63))});
                if (code == 2'd2) hl = $urandom_range(3, 8);
                else if (code == 2'd3) hl = $urandom_range(8, 13);
                else hl = $urandom_range(4);
                hdr.push_back(8'(hl));
                repeat (hl) hdr.push_back(8'($urandom));
                if (sid == psp_pkg::SID_PRIV1) begin
                    case ($urandom_range(4))
                        0: hdr.push_back(8'h80 + 8'($urandom_range(7)));
                        1: hdr.push_back(8'h88 + 8'($urandom_range(3)));
                        2: hdr.push_back(8'hA0 + 8'($urandom_range(7)));
                        3: hdr.push_back(8'h20 + 8'($urandom_range(7)));
                        default: hdr.push_back(8'($urandom));
                    endcase
                    repeat (6) hdr.push_back(8'($urandom));
                end
            end else begin
                repeat ($urandom_range(2)) hdr.push_back(8'hFF);
                if ($urandom_range(1)) begin
                    hdr.push_back(8'h40 | 8'($urandom_range(63)));
                    hdr.push_back(8'($urandom));
                end
                case ($urandom_range(5))
                    0: hdr.push_back(8'h0F);
                    1: begin
                        hdr.push_back(8'h20 | 8'($urandom_range(15)));
                        repeat (4) hdr.push_back(8'($urandom));
                    end
                    2, 3: begin
                        hdr.push_back(8'h30 | 8'($urandom_range(15)));
                        repeat (9) hdr.push_back(8'($urandom));
                    end
                    4: hdr.push_back(8'h10 | 8'($urandom_range(15)));
                    default: hdr.push_back(8'($urandom));
                endcase
            end
        end
        plen = $urandom_range(10);
        len = hdr.size() + plen;
        // a length too short for the header makes the packet underflow
        if ($urandom_range(9) == 0) len = $urandom_range(hdr.size());
        put_start(sid);
        put_byte(8'(len >> 8));
        put_byte(8'(len));
        for (k = 0; k < hdr.size(); k++) put_byte(hdr[k]);
        repeat (plen) put_byte(8'($urandom));
    endtask

    task automatic put_unit();
        int len;
        case ($urandom_range(19))
            0, 1: begin
                put_start(psp_pkg::SID_PACK);
                repeat (8) put_byte(8'($urandom));
            end
            2: begin
                put_start($urandom_range(1) ? psp_pkg::SID_PADDING : psp_pkg::SID_SYSTEM);
                len = $urandom_range(6);
                put_byte(8'(len >> 8));
                put_byte(8'(len));
                repeat (len) put_byte(8'($urandom));
            end
            3: begin
                repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
                case ($urandom_range(3))
                    0: put_start(8'hC9);
                    1: put_start(8'hE9);
                    2: put_start(8'h29);
                    default: put_start(8'($urandom));
                endcase
            end
            default: put_pes();
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (bytes_in_flight != 0 || expected_beats.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == psp_pkg::CFG_SELECTED) sel_sid = value;
        else pass_all = value[0];
    endtask

    logic [7:0] phase_sel[8] = '{8'hE0, 8'hC3, 8'h01, 8'h00, 8'hFF, 8'h27, 8'h40, 8'hE0};
    bit         phase_all[8] = '{0, 0, 1, 0, 1, 0, 0, 1};

    initial begin
        int p, goal;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // video packet with a pts of all ones, then an empty private stream 2 packet
        put_start(8'hE0);
        put_byte(8'h00);
        put_byte(8'h0A);
        put_byte(8'h80);
        put_byte(8'h80);
        put_byte(8'h05);
        repeat (5) put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h01);
        put_start(psp_pkg::SID_PRIV2);
        put_byte(8'h00);
        put_byte(8'h00);
        for (p = 0; p < 8; p++) begin
            if (p != 0) begin
                wait_drained();
                write_reg(psp_pkg::CFG_SELECTED, phase_sel[p]);
                write_reg(psp_pkg::CFG_PASS_ALL, {7'd0, phase_all[p]});
            end
            gaps_off = (p == 2);
            if (p == 4) hold_cycles = 400;
            goal = stream_bytes.size() + 195;
            while (stream_bytes.size() < goal) put_unit();
        end
        wait_drained();
        repeat (10) @(posedge aclk);
        if (errors == 0 && expected_beats.size() == 0) begin
            $display("** program_stream_pes_parser: PASSED **");
        end else begin
            $display("** program_stream_pes_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("** program_stream_pes_parser: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/psp_pkg.sv
hw/rtl/psp_out_reg.sv
hw/rtl/program_stream_pes_parser.sv
test/tb_top.sv
